@@ design/esgm_pkg.sv @@
// ----------------------------------------------------------------------------
// Envelope sum or geometric mean: shared types and constants
// Field widths, word layouts and register select codes used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package esgm_pkg;

    localparam int unsigned CHANNEL_W  = 4;
    localparam int unsigned SOURCE_W   = 3;
    localparam int unsigned LEVEL_W    = 16;
    localparam int unsigned COMBINED_W = 19;
    localparam int unsigned ACC_W      = 32;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned LIMB_W     = 32;
    localparam int unsigned POWER_W    = 128;
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 24;

    localparam logic [COUNT_W-1:0] MAX_SOURCES = 5'd8;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_ROOT = 1'b1;

    typedef logic [CHANNEL_W-1:0]  channel_t;
    typedef logic [SOURCE_W-1:0]   source_t;
    typedef logic [LEVEL_W-1:0]    level_t;
    typedef logic [COMBINED_W-1:0] combined_t;
    typedef logic [ACC_W-1:0]      acc_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [POWER_W-1:0]    power_t;

endpackage

`default_nettype wire

@@ design/envelope_sum_or_geometric_mean_top.sv @@
// ----------------------------------------------------------------------------
// Envelope sum or geometric mean: top level
// Per-channel sum or Q0.16 geometric mean of several source envelope levels.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word contents
//  s_        in         channel, source, level (one source level per word)
//  m_        out        out_channel, combined (one word per completed channel)
//  APB       in/out     combine_mode at 0x0, source_count at 0x4
//
//  A word that completes nothing returns to idle after its accumulator update; a
//  sum result or a single-source root goes straight on to the output handover.
//  A geometric mean of n sources runs a bit-serial root search before the output
//  handover: each of the 16 root bits loads a candidate, raises it to the n-th
//  power through one shared 32 x 16 multiplier, one 32-bit limb per cycle, then
//  compares once.
//  Reset clears the control state and the configuration registers; the accumulator RAM is
//  not cleared. s_tready is low while a word is in work or a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module envelope_sum_or_geometric_mean_top #(
    parameter int CHANNELS = 16
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // s_tdata: channel [3:0], source [6:4], level [22:7], zero [23]
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [esgm_pkg::IN_DATA_W-1:0]      s_tdata,
    // m_tdata: out_channel [3:0], combined [22:4], zero [23]
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [esgm_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [2:0]                          paddr,
    input  wire [31:0]                         pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_UPDATE    = 3'd1;
    localparam logic [2:0] ST_ROOT_INIT = 3'd2;
    localparam logic [2:0] ST_ROOT_SET  = 3'd3;
    localparam logic [2:0] ST_MUL       = 3'd4;
    localparam logic [2:0] ST_CMP       = 3'd5;
    localparam logic [2:0] ST_DONE      = 3'd6;

    logic                   mode_reg;
    logic [3:0]             count_reg;

    logic [2:0]             state_reg, state_next;
    esgm_pkg::channel_t     chan_reg, chan_next;
    esgm_pkg::source_t      src_reg, src_next;
    esgm_pkg::level_t       level_reg, level_next;
    logic                   imode_reg, imode_next;
    esgm_pkg::count_t       n_reg, n_next;
    esgm_pkg::acc_t         acc_reg, acc_next;
    esgm_pkg::power_t       target_reg, target_next;
    esgm_pkg::power_t       power_reg, power_next;
    logic [15:0]            carry_reg, carry_next;
    logic [15:0]            root_reg, root_next;
    logic [3:0]             bit_reg, bit_next;
    logic [1:0]             limb_reg, limb_next;
    logic [3:0]             mult_reg, mult_next;
    esgm_pkg::combined_t    result_reg, result_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    esgm_pkg::channel_t     out_chan_reg, out_chan_next;
    esgm_pkg::combined_t    out_comb_reg, out_comb_next;

    esgm_pkg::channel_t     in_channel;
    esgm_pkg::source_t      in_source;
    esgm_pkg::level_t       in_level;
    esgm_pkg::count_t       n_eff;
    logic                   in_take;
    logic                   in_useful;
    logic                   cfg_write;

    logic [esgm_pkg::LIMB_W-1:0] mul_a;
    logic [15:0]            mul_b;
    logic [47:0]            product;
    logic [47:0]            mul_sum;
    logic [15:0]            cand;
    logic [2:0]             shift_units;
    logic                   fits;
    logic                   last_src;
    logic                   last_mult;

    logic                   ram_we;
    esgm_pkg::acc_t         ram_rdata;

    assign in_channel = s_tdata[3:0];
    assign in_source  = s_tdata[6:4];
    assign in_level   = s_tdata[22:7];

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[2] == esgm_pkg::REG_COUNT) ? {28'd0, count_reg}
                                                         : {31'd0, mode_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= esgm_pkg::MODE_ADD;
            count_reg <= 4'd1;
        end else if (cfg_write) begin
            if (paddr[2] == esgm_pkg::REG_COUNT) begin
                count_reg <= pwdata[3:0];
            end else begin
                mode_reg <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (count_reg == 4'd0) begin
            n_eff = esgm_pkg::count_t'(1);
        end else if ({1'b0, count_reg} > esgm_pkg::MAX_SOURCES) begin
            n_eff = esgm_pkg::MAX_SOURCES;
        end else begin
            n_eff = {1'b0, count_reg};
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_take   = s_tvalid & s_tready;
    assign in_useful = (32'(in_channel) < CHANNELS) && ({2'b00, in_source} < n_eff);

    esgm_ram #(
        .WIDTH (esgm_pkg::ACC_W),
        .DEPTH (CHANNELS)
    ) u_acc_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (AW'(chan_reg)),
        .wr_data (acc_next),
        .rd_en   (in_take),
        .rd_addr (AW'(in_channel)),
        .rd_data (ram_rdata)
    );

    assign ram_we      = (state_reg == ST_UPDATE);
    assign cand        = root_reg | (16'd1 << bit_reg);
    assign mul_a       = (state_reg == ST_UPDATE) ? ram_rdata : power_reg[31:0];
    assign mul_b       = (state_reg == ST_UPDATE) ? level_reg : cand;
    assign product     = 48'(mul_a) * 48'(mul_b);
    assign mul_sum     = product + 48'(carry_reg);
    assign shift_units = 3'(n_reg - 5'd2);
    assign fits        = (power_reg <= target_reg);
    assign last_src    = ({2'b00, src_reg} == (n_reg - 5'd1));
    assign last_mult   = ({1'b0, mult_reg + 4'd1} == n_reg);

    always_comb begin
        state_next    = state_reg;
        chan_next     = chan_reg;
        src_next      = src_reg;
        level_next    = level_reg;
        imode_next    = imode_reg;
        n_next        = n_reg;
        acc_next      = acc_reg;
        target_next   = target_reg;
        power_next    = power_reg;
        carry_next    = carry_reg;
        root_next     = root_reg;
        bit_next      = bit_reg;
        limb_next     = limb_reg;
        mult_next     = mult_reg;
        result_next   = result_reg;
        m_tvalid_next = m_tvalid_reg;
        out_chan_next = out_chan_reg;
        out_comb_next = out_comb_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_take && in_useful) begin
                    chan_next  = in_channel;
                    src_next   = in_source;
                    level_next = in_level;
                    imode_next = mode_reg;
                    n_next     = n_eff;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (imode_reg == esgm_pkg::MODE_ADD) begin
                    acc_next = (src_reg == '0) ? esgm_pkg::acc_t'(level_reg)
                                               : ram_rdata + esgm_pkg::acc_t'(level_reg);
                end else begin
                    acc_next = (src_reg == '0) ? {level_reg, 16'd0} : product[47:16];
                end
                if (!last_src) begin
                    state_next = ST_IDLE;
                end else if (imode_reg == esgm_pkg::MODE_ADD) begin
                    result_next = acc_next[18:0];
                    state_next  = ST_DONE;
                end else if (n_reg == esgm_pkg::count_t'(1)) begin
                    result_next = {3'd0, acc_next[31:16]};
                    state_next  = ST_DONE;
                end else begin
                    state_next = ST_ROOT_INIT;
                end
            end
            ST_ROOT_INIT: begin
                target_next = esgm_pkg::power_t'(acc_reg) << {shift_units, 4'd0};
                root_next   = 16'd0;
                bit_next    = 4'd15;
                state_next  = ST_ROOT_SET;
            end
            ST_ROOT_SET: begin
                power_next = esgm_pkg::power_t'(cand);
                carry_next = 16'd0;
                limb_next  = 2'd0;
                mult_next  = 4'd1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                power_next = {mul_sum[31:0], power_reg[esgm_pkg::POWER_W-1:esgm_pkg::LIMB_W]};
                carry_next = mul_sum[47:32];
                limb_next  = limb_reg + 2'd1;
                if (limb_reg == 2'd3) begin
                    carry_next = 16'd0;
                    mult_next  = mult_reg + 4'd1;
                    if (last_mult) begin
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                if (fits) begin
                    root_next = cand;
                end
                if (bit_reg == 4'd0) begin
                    result_next = {3'd0, root_next};
                    state_next  = ST_DONE;
                end else begin
                    bit_next   = bit_reg - 4'd1;
                    state_next = ST_ROOT_SET;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    out_chan_next = chan_reg;
                    out_comb_next = result_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chan_reg     <= chan_next;
        src_reg      <= src_next;
        level_reg    <= level_next;
        imode_reg    <= imode_next;
        n_reg        <= n_next;
        acc_reg      <= acc_next;
        target_reg   <= target_next;
        power_reg    <= power_next;
        carry_reg    <= carry_next;
        root_reg     <= root_next;
        bit_reg      <= bit_next;
        limb_reg     <= limb_next;
        mult_reg     <= mult_next;
        result_reg   <= result_next;
        out_chan_reg <= out_chan_next;
        out_comb_reg <= out_comb_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_comb_reg, out_chan_reg};

endmodule

`default_nettype wire

@@ design/esgm_ram.sv @@
// ----------------------------------------------------------------------------
// Envelope sum or geometric mean: generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module esgm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                                     aclk,
    input  wire                                     wr_en,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire [WIDTH-1:0]                         wr_data,
    input  wire                                     rd_en,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire
